// ----- hw/rtl/sst_pkg.sv -----
// Shared constants, codes and controller/datapath types for the small set table.
package sst_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int CMD_W    = 2;
  localparam int ST_W     = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_POP      = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_POP_RD,
    S_POP_TAKE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic latch;
    logic step;
    logic shift_wr;
    logic start_shift;
    logic set_found;
    logic set_full;
    logic set_empty;
    logic ins_wr;
    logic dec_count;
    logic pop_rd;
    logic pop_take;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             match;
    logic             idx_end;
    logic             rd_vld;
    logic             full;
    logic             empty;
    logic             out_free;
  } dp_stat_t;

endpackage

// ----- hw/rtl/sst_if.sv -----
// Valid/ready channel interfaces for command beats and result beats.
interface sst_req_if;
  logic                            valid;
  logic                            ready;
  logic [sst_pkg::CMD_W-1:0]       cmd;
  logic signed [sst_pkg::VAL_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface sst_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic signed [sst_pkg::VAL_W-1:0] popped_value;
  logic [sst_pkg::CNT_W-1:0]        element_count;
  logic [sst_pkg::ST_W-1:0]         status;

  modport source (output valid, output found, output popped_value, output element_count,
                  output status, input ready);
  modport sink   (input valid, input found, input popped_value, input element_count,
                  input status, output ready);
endinterface

// ----- hw/rtl/small_set_table.sv -----
// Top level of the small set table: sequencer plus element store datapath.
//
//   channel | dir | payload                                       | handshake
//   req     | in  | cmd[1:0], value[31:0]                         | valid/ready
//   rsp     | out | found, popped_value, element_count, status    | valid/ready
//
// One command at a time. Insert/contains scan the store, one store read per cycle
// through the registered read port. Remove adds compaction after a hit, one entry
// moved per cycle.
// Synchronous reset empties the set; store contents are not cleared.
// A stalled rsp holds the finished beat; the next command waits in the last step.
module small_set_table (
  input  logic          clk,
  input  logic          rst,
  sst_req_if.sink       req,
  sst_rsp_if.source     rsp
);

  sst_pkg::dp_cmd_t  ctl;
  sst_pkg::dp_stat_t stat;

  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  sst_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .stat              (stat),
    .cmd               (req.cmd),
    .value             (req.value),
    .rsp_ready         (rsp.ready),
    .rsp_valid         (rsp.valid),
    .rsp_found         (rsp.found),
    .rsp_popped_value  (rsp.popped_value),
    .rsp_element_count (rsp.element_count),
    .rsp_status        (rsp.status)
  );

endmodule

// ----- hw/rtl/sst_datapath.sv -----
// Element store, scan/shift indexes, count and result registers.
module sst_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  sst_pkg::dp_cmd_t                 ctl,
  output sst_pkg::dp_stat_t                stat,
  input  logic [sst_pkg::CMD_W-1:0]        cmd,
  input  logic signed [sst_pkg::VAL_W-1:0] value,
  input  logic                             rsp_ready,
  output logic                             rsp_valid,
  output logic                             rsp_found,
  output logic signed [sst_pkg::VAL_W-1:0] rsp_popped_value,
  output logic [sst_pkg::CNT_W-1:0]        rsp_element_count,
  output logic [sst_pkg::ST_W-1:0]         rsp_status
);

  logic signed [sst_pkg::VAL_W-1:0] mem [sst_pkg::CAPACITY];

  logic [sst_pkg::CMD_W-1:0]        cmd_q;
  logic signed [sst_pkg::VAL_W-1:0] value_q;
  logic [sst_pkg::CNT_W-1:0]        idx;
  logic [sst_pkg::IDX_W-1:0]        rd_idx;
  logic                             rd_vld;
  logic signed [sst_pkg::VAL_W-1:0] rdata;
  logic [sst_pkg::CNT_W-1:0]        count;
  logic                             found_q;
  logic [sst_pkg::ST_W-1:0]         status_q;
  logic signed [sst_pkg::VAL_W-1:0] popped_q;

  logic                             idx_lt;
  logic                             rd_en;
  logic [sst_pkg::CNT_W-1:0]        count_m1;
  logic [sst_pkg::IDX_W-1:0]        rd_addr;

  assign idx_lt   = idx < count;
  assign count_m1 = count - sst_pkg::CNT_W'(1);
  assign rd_en    = ctl.pop_rd || ((ctl.step || ctl.shift_wr) && idx_lt);
  assign rd_addr  = ctl.pop_rd ? count_m1[sst_pkg::IDX_W-1:0] : idx[sst_pkg::IDX_W-1:0];

  // store: append on insert, move entry down during remove compaction
  always_ff @(posedge clk) begin
    if (ctl.ins_wr) begin
      mem[count[sst_pkg::IDX_W-1:0]] <= value_q;
    end else if (ctl.shift_wr && rd_vld) begin
      mem[rd_idx - sst_pkg::IDX_W'(1)] <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata  <= mem[rd_addr];
      rd_idx <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_q   <= cmd;
      value_q <= value;
    end
    if (ctl.latch) begin
      idx <= '0;
    end else if (ctl.start_shift) begin
      idx <= sst_pkg::CNT_W'(rd_idx) + sst_pkg::CNT_W'(1);
    end else if ((ctl.step || ctl.shift_wr) && idx_lt) begin
      idx <= idx + sst_pkg::CNT_W'(1);
    end
    if (ctl.latch) begin
      found_q  <= 1'b0;
      status_q <= sst_pkg::ST_OK;
      popped_q <= '0;
    end else begin
      if (ctl.set_found) found_q  <= 1'b1;
      if (ctl.set_full)  status_q <= sst_pkg::ST_FULL;
      if (ctl.set_empty) status_q <= sst_pkg::ST_EMPTY;
      if (ctl.pop_take)  popped_q <= rdata;
    end
    if (ctl.load_out) begin
      rsp_found         <= found_q;
      rsp_status        <= status_q;
      rsp_popped_value  <= popped_q;
      rsp_element_count <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (ctl.ins_wr) begin
        count <= count + sst_pkg::CNT_W'(1);
      end else if (ctl.dec_count || ctl.pop_take) begin
        count <= count_m1;
      end
      if (ctl.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.cmd      = cmd_q;
    stat.match    = rd_vld && (rdata == value_q);
    stat.idx_end  = (idx == count);
    stat.rd_vld   = rd_vld;
    stat.full     = (count == sst_pkg::CNT_W'(sst_pkg::CAPACITY));
    stat.empty    = (count == '0);
    stat.out_free = !rsp_valid || rsp_ready;
  end

endmodule

// ----- hw/rtl/sst_ctrl.sv -----
// Command sequencer: search, compaction, pop and result hand-off.
module sst_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  sst_pkg::dp_stat_t  stat,
  output sst_pkg::dp_cmd_t   ctl
);

  sst_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sst_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = sst_pkg::S_SCAN;
        end
      end
      sst_pkg::S_SCAN: begin
        if (stat.cmd == sst_pkg::CMD_POP) begin
          state_next = sst_pkg::S_POP_RD;
        end else if (stat.match) begin
          state_next = (stat.cmd == sst_pkg::CMD_REMOVE) ? sst_pkg::S_SHIFT
                                                         : sst_pkg::S_FINISH;
        end else if (stat.idx_end) begin
          state_next = sst_pkg::S_FINISH;
        end
      end
      sst_pkg::S_SHIFT: begin
        if (stat.idx_end && !stat.rd_vld) begin
          state_next = sst_pkg::S_FINISH;
        end
      end
      sst_pkg::S_POP_RD: begin
        state_next = stat.empty ? sst_pkg::S_FINISH : sst_pkg::S_POP_TAKE;
      end
      sst_pkg::S_POP_TAKE: begin
        state_next = sst_pkg::S_FINISH;
      end
      sst_pkg::S_FINISH: begin
        if (stat.out_free) begin
          state_next = sst_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sst_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl       = '0;
    req_ready = 1'b0;
    unique case (state)
      sst_pkg::S_IDLE: begin
        req_ready = 1'b1;
        ctl.latch = req_valid;
      end
      sst_pkg::S_SCAN: begin
        // pop skips the search; the beat was latched and is decoded here
        if (stat.cmd != sst_pkg::CMD_POP) begin
          if (stat.match) begin
            ctl.set_found   = 1'b1;
            ctl.start_shift = (stat.cmd == sst_pkg::CMD_REMOVE);
          end else if (stat.idx_end) begin
            if (stat.cmd == sst_pkg::CMD_INSERT) begin
              ctl.set_full = stat.full;
              ctl.ins_wr   = !stat.full;
            end
          end else begin
            ctl.step = 1'b1;
          end
        end
      end
      sst_pkg::S_SHIFT: begin
        if (stat.idx_end && !stat.rd_vld) begin
          ctl.dec_count = 1'b1;
        end else begin
          ctl.shift_wr = 1'b1;
        end
      end
      sst_pkg::S_POP_RD: begin
        ctl.set_empty = stat.empty;
        ctl.pop_rd    = !stat.empty;
      end
      sst_pkg::S_POP_TAKE: begin
        ctl.pop_take = 1'b1;
      end
      sst_pkg::S_FINISH: begin
        ctl.load_out = stat.out_free;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/sst_checker.sv -----
// Port-level checks for the small set table, bound to the top level.
module sst_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_valid,
  input logic                             req_ready,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic                             rsp_found,
  input logic signed [sst_pkg::VAL_W-1:0] rsp_popped_value,
  input logic [sst_pkg::CNT_W-1:0]        rsp_element_count,
  input logic [sst_pkg::ST_W-1:0]         rsp_status
);

  // a full rejection only happens with the store at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == sst_pkg::ST_FULL)
      |-> (rsp_element_count == sst_pkg::CNT_W'(sst_pkg::CAPACITY)) && !rsp_found)
    else $error("full status with count below capacity");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == sst_pkg::ST_EMPTY)
      |-> (rsp_element_count == '0) && (rsp_popped_value == '0) && !rsp_found)
    else $error("empty status with nonzero count or data");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_element_count <= sst_pkg::CNT_W'(sst_pkg::CAPACITY))
    else $error("element count above capacity");

  // one command in flight: no new beat right after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("command accepted while busy");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element_count))
    else $error("result beat dropped while stalled");

endmodule

bind small_set_table sst_checker u_sst_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_found         (rsp.found),
  .rsp_popped_value  (rsp.popped_value),
  .rsp_element_count (rsp.element_count),
  .rsp_status        (rsp.status)
);

// ----- sim/small_set_table_tb.sv -----
// Self-checking testbench for small_set_table: directed table, then random beats.
module small_set_table_tb;
  import sst_pkg::*;

  localparam int RANDOM_BEATS = 1900;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int POOL_SIZE    = 24;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] popped_value;
    logic [CNT_W-1:0] element_count;
    logic [ST_W-1:0]  status;
  } set_result_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] value;
    bit               typed;
    set_result_t      result;
  } stim_row_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_PATTERN,
    RDY_BUSY,
    RDY_COIN
  } stall_mode_t;

  logic clk;
  logic rst;

  sst_req_if req_bus ();
  sst_rsp_if rsp_bus ();

  small_set_table u_top (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // Shadow copy of the set
  logic [VAL_W-1:0] shadow_elems [CAPACITY];
  int               shadow_count;

  set_result_t      pending_results[$];
  stim_row_t        directed_rows[$];
  logic [VAL_W-1:0] value_pool [POOL_SIZE];

  int          errors        = 0;
  int          cycle_count   = 0;
  int          burst_left;
  stall_mode_t ready_mode    = RDY_ALWAYS;
  logic [15:0] ready_pattern = 16'hffff;
  logic [7:0]  ready_tick    = '0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic set_result_t apply_set_cmd(input logic [CMD_W-1:0] c,
                                                input logic [VAL_W-1:0] v);
    set_result_t r;
    int          pos;
    int          i;
    r   = '0;
    pos = shadow_count;
    for (i = shadow_count - 1; i >= 0; i--)
      if (shadow_elems[i] == v) pos = i;
    case (c)
      CMD_INSERT: begin
        if (pos < shadow_count) begin
          r.found = 1'b1;
        end else if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_elems[shadow_count] = v;
          shadow_count++;
        end
      end
      CMD_CONTAINS: r.found = (pos < shadow_count);
      CMD_REMOVE: begin
        if (pos < shadow_count) begin
          r.found = 1'b1;
          for (i = pos; i + 1 < shadow_count; i++) shadow_elems[i] = shadow_elems[i+1];
          shadow_count--;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_count--;
          r.popped_value = shadow_elems[shadow_count];
        end
      end
    endcase
    r.element_count = shadow_count[CNT_W-1:0];
    return r;
  endfunction

  function automatic void add_row(input logic [CMD_W-1:0] c, input logic [VAL_W-1:0] v,
                                  input bit typed, input logic found,
                                  input logic [VAL_W-1:0] popped, input int cnt,
                                  input logic [ST_W-1:0] st);
    stim_row_t row;
    row.cmd                  = c;
    row.value                = v;
    row.typed                = typed;
    row.result.found         = found;
    row.result.popped_value  = popped;
    row.result.element_count = cnt[CNT_W-1:0];
    row.result.status        = st;
    directed_rows.push_back(row);
  endfunction

  // Holds the beat until accepted, then books its expected result.
  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [VAL_W-1:0] v,
                          input bit typed, input set_result_t typed_res);
    set_result_t predicted;
    req_bus.valid <= 1'b1;
    req_bus.cmd   <= c;
    req_bus.value <= v;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    predicted = apply_set_cmd(c, v);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Receiver: re-picks its stall behavior whenever the low six bits of ready_tick are zero
  always @(posedge clk) begin
    ready_tick <= ready_tick + 8'd1;
    if (ready_tick[5:0] == 6'd0) begin
      ready_mode    <= stall_mode_t'($urandom_range(0, 3));
      ready_pattern <= 16'($urandom);
    end
    case (ready_mode)
      RDY_ALWAYS:  rsp_bus.ready <= 1'b1;
      RDY_PATTERN: rsp_bus.ready <= ready_pattern[ready_tick[3:0]];
      RDY_BUSY:    rsp_bus.ready <= ($urandom_range(0, 3) == 0);
      default:     rsp_bus.ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // Result checker
  always @(posedge clk) begin
    set_result_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (rsp_bus.found !== want.found)
          report_mismatch($sformatf("found %b, want %b", rsp_bus.found, want.found));
        if (rsp_bus.popped_value !== want.popped_value)
          report_mismatch($sformatf("popped_value %h, want %h",
                                    rsp_bus.popped_value, want.popped_value));
        if (rsp_bus.element_count !== want.element_count)
          report_mismatch($sformatf("element_count %0d, want %0d",
                                    rsp_bus.element_count, want.element_count));
        if (rsp_bus.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", rsp_bus.status, want.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("small_set_table regression: fail");
      $finish;
    end
  end

  initial begin
    logic [CMD_W-1:0] c;
    logic [VAL_W-1:0] v;
    int               insert_bias;
    int               roll;
    int               k;
    int               n;

    rst           = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.cmd   = CMD_INSERT;
    req_bus.value = '0;
    burst_left    = 0;
    shadow_count  = 0;
    insert_bias   = 50;
    for (k = 0; k < CAPACITY; k++) shadow_elems[k] = '0;

    // Directed table
    add_row(CMD_POP,      32'h0000_0000, 1, 1'b0, 32'h0, 0, ST_EMPTY);
    add_row(CMD_REMOVE,   32'h0000_0005, 1, 1'b0, 32'h0, 0, ST_OK);
    add_row(CMD_INSERT,   32'h8000_0000, 1, 1'b0, 32'h0, 1, ST_OK);
    add_row(CMD_INSERT,   32'h7fff_ffff, 1, 1'b0, 32'h0, 2, ST_OK);
    add_row(CMD_INSERT,   32'h0000_0000, 1, 1'b0, 32'h0, 3, ST_OK);
    add_row(CMD_INSERT,   32'hffff_ffff, 1, 1'b0, 32'h0, 4, ST_OK);
    add_row(CMD_INSERT,   32'h7fff_ffff, 1, 1'b1, 32'h0, 4, ST_OK);
    add_row(CMD_CONTAINS, 32'h8000_0000, 1, 1'b1, 32'h0, 4, ST_OK);
    add_row(CMD_REMOVE,   32'h8000_0000, 1, 1'b1, 32'h0, 3, ST_OK);  // head: shifts all
    add_row(CMD_POP,      32'hffff_ffff, 1, 1'b0, 32'hffff_ffff, 2, ST_OK);
    for (k = 1; k <= CAPACITY - 2; k++)
      add_row(CMD_INSERT, 32'h0101_0101 * k, 0, 1'b0, 32'h0, 0, ST_OK);
    add_row(CMD_INSERT,   32'h5555_5555, 1, 1'b0, 32'h0, CAPACITY, ST_FULL);
    add_row(CMD_INSERT,   32'h7fff_ffff, 1, 1'b1, 32'h0, CAPACITY, ST_OK);
    add_row(CMD_REMOVE,   32'h0707_0707, 0, 1'b0, 32'h0, 0, ST_OK);  // mid-store remove
    add_row(CMD_POP,      32'haaaa_aaaa, 0, 1'b0, 32'h0, 0, ST_OK);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].typed,
               directed_rows[i].result);
      pace_sender();
    end

    // Random part: small value pool so hits, duplicates and a full store are common
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 256 == 0) begin
        for (k = 0; k < POOL_SIZE; k++)
          value_pool[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom;
      end
      // Drift the fill level between empty and full
      if (n % 96 == 0) insert_bias = $urandom_range(10, 90);
      roll = $urandom_range(0, 99);
      if (roll < insert_bias) begin
        c = CMD_INSERT;
      end else begin
        roll = $urandom_range(0, 9);
        c = (roll < 3) ? CMD_CONTAINS : (roll < 7) ? CMD_REMOVE : CMD_POP;
      end
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (roll < 80) begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          2:       v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end else begin
        v = $urandom;
      end
      send_cmd(c, v, 0, '0);
      pace_sender();
    end

    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("small_set_table regression: pass");
    end else begin
      $display("small_set_table regression: fail");
    end
    $finish;
  end

endmodule
